// File: sv/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block sorter package
// Shared action codes, field widths and the control bundle that drives the
// row of sorting cells.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int VALUE_W = 16;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef struct packed {
    logic load;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: sv/bsa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one element of the ascending row. On a load it keeps its element,
// takes its left neighbor's element or takes the new value; on a pop it takes
// its right neighbor's element.
// ----------------------------------------------------------------------------
module bsa_cell #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bsa_pkg::cell_ctl_t    ctl,
  input  wire logic [DATA_WIDTH-1:0] load_value,
  input  wire logic [DATA_WIDTH-1:0] left_held,
  input  wire logic                  left_occ,
  input  wire logic                  left_gt,
  input  wire logic [DATA_WIDTH-1:0] right_held,
  input  wire logic                  right_occ,
  output logic [DATA_WIDTH-1:0]      held,
  output logic                       occ,
  output logic                       gt
);
  import bsa_pkg::*;

  assign gt = !occ || (held > load_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.load) begin
      if (gt) begin
        occ <= left_gt ? left_occ : 1'b1;
      end
    end else if (ctl.pop) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (gt) begin
        held <= left_gt ? left_held : load_value;
      end
    end else if (ctl.pop) begin
      held <= right_held;
    end
  end

endmodule
`default_nettype wire

// File: sv/block_sorter_ascending_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block sorter, ascending
// Insertion sorter built from a row of NUM_ELEMENTS cells. One transaction is
// taken per cycle while no response is held stalled. A load compares the new
// value against every cell at once; cells above the insertion point hand
// their element one place to the right, so the row is always sorted. Once
// NUM_ELEMENTS values are held, each read returns the smallest one from the
// head cell and shifts the row one place left; its result is presented the
// cycle after acceptance from an output register. The read of the final
// element is marked last and leaves the block empty for the next set. Reads
// before the set is complete return valid_res low; loads while a full set is
// held are dropped.
// ----------------------------------------------------------------------------
module block_sorter_ascending_top #(
  parameter int NUM_ELEMENTS = 128,
  parameter int DATA_WIDTH   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic                        action,
  input  wire logic [bsa_pkg::VALUE_W-1:0] value,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic [bsa_pkg::VALUE_W-1:0]      sorted_value,
  output logic                             last,
  output logic                             valid_res
);
  import bsa_pkg::*;

  localparam int CNT_W = $clog2(NUM_ELEMENTS + 1);

  logic                  req_fire;
  logic                  is_read;
  logic                  good_read;
  logic [DATA_WIDTH-1:0] load_value;
  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      count;
  logic                  full;

  logic [DATA_WIDTH-1:0] cell_held [NUM_ELEMENTS];
  logic                  cell_occ  [NUM_ELEMENTS];
  logic                  cell_gt   [NUM_ELEMENTS];

  assign req_ready  = !rsp_valid || rsp_ready;
  assign req_fire   = req_valid && req_ready;
  assign is_read    = (action_t'(action) == ACT_READ);
  assign good_read  = is_read && full;
  assign load_value = DATA_WIDTH'(value);

  assign ctl.load = req_fire && !is_read && !full;
  assign ctl.pop  = req_fire && good_read;

  for (genvar i = 0; i < NUM_ELEMENTS; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_held;
    logic                  l_occ;
    logic                  l_gt;
    logic [DATA_WIDTH-1:0] r_held;
    logic                  r_occ;

    if (i == 0) begin : g_head
      assign l_held = '0;
      assign l_occ  = 1'b0;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_held = cell_held[i-1];
      assign l_occ  = cell_occ[i-1];
      assign l_gt   = cell_gt[i-1];
    end

    if (i == NUM_ELEMENTS - 1) begin : g_tail
      assign r_held = '0;
      assign r_occ  = 1'b0;
    end else begin : g_body
      assign r_held = cell_held[i+1];
      assign r_occ  = cell_occ[i+1];
    end

    bsa_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .load_value(load_value),
      .left_held (l_held),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .right_held(r_held),
      .right_occ (r_occ),
      .held      (cell_held[i]),
      .occ       (cell_occ[i]),
      .gt        (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      full      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.load) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(NUM_ELEMENTS - 1)) begin
          full <= 1'b1;
        end
      end
      if (ctl.pop) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          full <= 1'b0;
        end
      end
      if (req_fire && is_read) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && is_read) begin
      if (good_read) begin
        sorted_value <= VALUE_W'(cell_held[0]);
        last         <= (count == CNT_W'(1));
        valid_res    <= 1'b1;
      end else begin
        sorted_value <= '0;
        last         <= 1'b0;
        valid_res    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/bsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block sorter port checker
// Watches the top-level ports for result framing and handshake rules.
// ----------------------------------------------------------------------------
module bsa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        action,
  input wire logic [bsa_pkg::VALUE_W-1:0] value,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [bsa_pkg::VALUE_W-1:0] sorted_value,
  input wire logic                        last,
  input wire logic                        valid_res
);
  import bsa_pkg::*;

  a_no_rsp_after_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_read_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && action_t'(action) == ACT_READ) |=> rsp_valid)
    else $error("accepted read produced no response");

  a_last_is_good: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && last) |-> valid_res)
    else $error("last mark on an early read");

  a_early_read_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !valid_res) |-> (sorted_value == '0 && !last))
    else $error("early read carries data");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(sorted_value)
                                   && $stable(last) && $stable(valid_res)))
    else $error("stalled response changed");

endmodule

bind block_sorter_ascending_top bsa_checker u_bsa_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block sorter testbench
// Loads full sets of 16-bit values into the ascending block sorter and reads
// them back, checking every read against a software insertion sorter kept in
// a small scoreboard. Covers early reads, loads into a full set, corner
// values, many duplicates and presorted data. Both handshakes idle at random,
// and the response side holds off for a long stretch once so that the block
// backs up and stalls its request side.
// ----------------------------------------------------------------------------
module tb_top;
  import bsa_pkg::*;

  localparam int NUM_ELEMENTS = 128;
  localparam int DATA_WIDTH   = 16;
  localparam int CLK_HALF     = 6;
  localparam int RANDOM_ITEMS = 700;
  localparam int LONG_HOLD    = 300;
  localparam int CHUNK        = 32;
  localparam int MAX_CYCLES   = 1_500_000;

  typedef logic [VALUE_W-1:0] elem_t;

  localparam elem_t KEEP_MASK = elem_t'((64'd1 << DATA_WIDTH) - 64'd1);

  typedef struct {
    elem_t value;
    logic  last;
    logic  good;
  } sorted_out_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RISING,
    FILL_FALLING,
    FILL_SAME,
    FILL_EDGES
  } fill_style_t;

  class sort_scoreboard;
    elem_t       rank[NUM_ELEMENTS];
    int          held     = 0;
    int          next_out = 0;
    bit          full     = 0;
    int          errors   = 0;
    sorted_out_t due[$];

    function void note_request(action_t act, elem_t v);
      elem_t       kept;
      int          k;
      sorted_out_t r;
      kept = v & KEEP_MASK;
      if (act == ACT_LOAD) begin
        if (!full && held < NUM_ELEMENTS) begin
          k = held;
          while (k > 0 && rank[k-1] > kept) begin
            rank[k] = rank[k-1];
            k--;
          end
          rank[k] = kept;
          held++;
          if (held >= NUM_ELEMENTS) full = 1;
        end
      end else begin
        if (!full || next_out >= NUM_ELEMENTS) begin
          r.value = '0;
          r.last  = 1'b0;
          r.good  = 1'b0;
        end else begin
          r.value = rank[next_out];
          r.good  = 1'b1;
          r.last  = (next_out == NUM_ELEMENTS - 1);
          if (r.last) begin
            next_out = 0;
            held     = 0;
            full     = 0;
          end else begin
            next_out++;
          end
        end
        due.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(elem_t v, logic lst, logic good);
      sorted_out_t e;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result sorted_value=%h last=%b valid_res=%b",
                                  v, lst, good));
        return;
      end
      e = due.pop_front();
      if (v !== e.value)
        report_mismatch($sformatf("sorted_value %h, want %h", v, e.value));
      if (lst !== e.last)
        report_mismatch($sformatf("last %b, want %b", lst, e.last));
      if (good !== e.good)
        report_mismatch($sformatf("valid_res %b, want %b", good, e.good));
    endtask
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    req_valid    = 1'b0;
  logic    req_ready;
  action_t req_action   = ACT_LOAD;
  elem_t   req_value    = '0;
  logic    rsp_valid;
  logic    rsp_ready    = 1'b0;
  elem_t   sorted_value;
  logic    last;
  logic    valid_res;

  sort_scoreboard sb;
  bit             tx_quiet    = 0;
  bit             hold_wanted = 0;
  bit             hold_taken  = 0;
  int             counted     = 0;

  block_sorter_ascending_top #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .action      (req_action),
    .value       (req_value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .sorted_value(sorted_value),
    .last        (last),
    .valid_res   (valid_res)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic elem_t fill_value(fill_style_t style, int idx, elem_t seed);
    case (style)
      FILL_NARROW:  return elem_t'($urandom_range(0, 7));
      FILL_RISING:  return seed + elem_t'(idx * 3);
      FILL_FALLING: return seed - elem_t'(idx * 5);
      FILL_SAME:    return seed;
      FILL_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return elem_t'(1) << $urandom_range(0, VALUE_W - 1);
          default: return ~(elem_t'(1) << $urandom_range(0, VALUE_W - 1));
        endcase
      end
      default:      return elem_t'($urandom);
    endcase
  endfunction

  task automatic send_req(action_t act, elem_t v);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_action <= act;
    req_value  <= v;
    do @(posedge clk); while (!req_ready);
    if (act == ACT_READ || !sb.full) counted++;
    sb.note_request(act, v);
  endtask

  // Fill one set in styled chunks (noisy: stray reads/loads), then drain it.
  task automatic run_set(int base, bit noisy, bit squeeze);
    elem_t seed;
    int    idx;
    seed = '0;
    idx  = 0;
    while (!sb.full) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        send_req(ACT_READ, elem_t'($urandom));
      end else begin
        if (idx % CHUNK == 0) seed = elem_t'($urandom);
        send_req(ACT_LOAD, fill_value(fill_style_t'((idx / CHUNK + base) % 6), idx, seed));
        idx++;
      end
    end
    if (noisy && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_req(ACT_LOAD, elem_t'($urandom));
    if (squeeze) hold_wanted = 1'b1;
    while (sb.full) send_req(ACT_READ, elem_t'($urandom));
  endtask

  initial begin : stimulus
    elem_t corner[10];
    int    set_no;
    corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
               16'hFFFE, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000};
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_req(ACT_READ, 16'h1234);
    foreach (corner[i]) send_req(ACT_LOAD, corner[i]);
    send_req(ACT_READ, 16'hFFFF);
    while (!sb.full) send_req(ACT_LOAD, elem_t'($urandom));
    send_req(ACT_LOAD, 16'h0000);
    send_req(ACT_LOAD, 16'hFFFF);
    while (sb.full) send_req(ACT_READ, elem_t'($urandom));
    send_req(ACT_READ, 16'h0000);

    counted = 0;
    set_no  = 0;
    while (counted < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      run_set(set_no * 4 + 1, $urandom_range(0, 1), set_no == 1);
      set_no++;
    end
    req_valid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin : drain
    int stall_left;
    int phase_left;
    bit rx_quiet;
    stall_left = 0;
    phase_left = 0;
    rx_quiet   = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) sb.check_result(sorted_value, last, valid_res);
      if (phase_left == 0) begin
        rx_quiet   = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD - 1;
        rsp_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(2 * CLK_HALF * MAX_CYCLES);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
sv/bsa_pkg.sv
sv/bsa_cell.sv
sv/block_sorter_ascending_top.sv
sv/bsa_checker.sv
tb/tb_top.sv
